@@ rtl/knnh_pkg.sv @@
// Shared types and constants for the neighbor heap update core.
`default_nettype none
package knnh_pkg;

    localparam int DIST_W = 32;
    localparam int ID_W = 10;
    localparam int FCNT_W = 5;
    localparam int RCNT_W = 11;

    localparam logic [DIST_W-1:0] SEED_DISTANCE = 32'h7F7F_FFFF;
    localparam logic [FCNT_W-1:0] FWD_LIMIT = 5'd31;
    localparam logic [RCNT_W-1:0] REV_LIMIT = 11'd2047;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic [ID_W-1:0]   id;
        logic              is_new;
    } entry_t;

    typedef struct packed {
        logic [RCNT_W-1:0] rnew;
        logic [RCNT_W-1:0] rold;
    } rev_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NODE_RD,
        ST_NODE_CHK,
        ST_ROOT_RD,
        ST_ROOT_CHK,
        ST_SCAN,
        ST_SU_RD,
        ST_SU_CMP,
        ST_REV_RD_OLD,
        ST_REV_WR_OLD,
        ST_REV_RD_ID,
        ST_REV_WR_ID,
        ST_NODE_WR,
        ST_SD_RL,
        ST_SD_RR,
        ST_SD_CMP,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/knnh_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module knnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/knn_heap_neighbor_update_core.sv @@
// Top level: per-node bounded max-heap neighbor store with link counters.
// Request time is set by the duplicate scan and the sift through the
// single-read-port entry memory. One request at a time. Reset: a clearing
// pass zeroes the node memory; no request is taken until it ends.
`default_nettype none
module knn_heap_neighbor_update_core #(
    parameter int NODES = 1024,
    parameter int NEIGHBOURS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [knnh_pkg::ID_W-1:0] first_node,
    input  wire logic [knnh_pkg::ID_W-1:0] second_node,
    input  wire logic [knnh_pkg::DIST_W-1:0] distance,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  accepted_count,
    output logic                        heap_not_full
);
    import knnh_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int FW = $clog2(NEIGHBOURS + 1);
    localparam int PW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int CW = PW + 2;
    localparam int SLOTS = NODES * NEIGHBOURS;
    localparam int AW = $clog2(SLOTS);
    localparam int EW = $bits(entry_t);
    localparam int NDW = FW + 2 * FCNT_W;
    localparam int RW = $bits(rev_t);
    localparam int NRW = NDW + RW;
    localparam logic [FW-1:0] K_FILL = FW'(NEIGHBOURS);

    state_t state_reg, state_next;

    logic              op_reg;
    logic [ID_W-1:0]   a_reg, b_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              dir_reg;
    logic [1:0]        acc_reg;
    logic              nf_reg;
    logic [FW-1:0]     fill_reg;
    logic [FCNT_W-1:0] fnew_reg, fold_reg;
    entry_t            root_reg, cur_reg, lft_reg;
    logic [PW-1:0]     pos_reg;
    logic              rok_reg;
    logic [FW-1:0]     scan_idx_reg;
    logic              scan_vld_reg;
    logic [NW-1:0]     clr_reg;
    logic              out_valid_reg;
    logic [1:0]        acc_out_reg;
    logic              nf_out_reg;

    logic [ID_W-1:0] node_id, peer_id;
    logic [NW-1:0]   node_idx;
    logic            in_ok;
    logic            out_free;

    logic          ent_we, ent_re;
    logic [PW-1:0] ent_widx, ent_ridx;
    entry_t        ent_wdata, ent_rdata;
    logic [EW-1:0] ent_rword;
    logic [AW-1:0] ent_base, ent_waddr, ent_raddr;

    logic           nd_we, nd_re;
    logic [NW-1:0]  nd_waddr, nd_raddr;
    logic [NRW-1:0] nd_wdata, nd_rdata;

    rev_t          rv_wdata, rv_rdata;

    logic [CW-1:0] l_idx, r_idx;
    logic [PW-1:0] par_idx;
    logic          l_in, r_in;
    logic          l_big, r_big, sd_move;
    entry_t        sd_best, sd_child;
    logic [PW-1:0] sd_top;
    logic          scan_hit, scan_more;

    assign node_id  = dir_reg ? b_reg : a_reg;
    assign peer_id  = dir_reg ? a_reg : b_reg;
    assign node_idx = NW'(node_id);
    assign in_ok    = (32'(first_node) < NODES) && (32'(second_node) < NODES)
                    && ((operation == OP_SEED) || (first_node != second_node));
    assign out_free = !out_valid_reg || !out_stall;

    assign ent_base  = AW'(node_idx) * AW'(NEIGHBOURS);
    assign ent_waddr = ent_base + AW'(ent_widx);
    assign ent_raddr = ent_base + AW'(ent_ridx);
    assign ent_rdata = entry_t'(ent_rword);
    assign rv_rdata  = rev_t'(nd_rdata[RW-1:0]);

    assign l_idx   = {pos_reg, 1'b1} + CW'(0);
    assign r_idx   = l_idx + CW'(1);
    assign l_in    = l_idx < CW'(fill_reg);
    assign r_in    = r_idx < CW'(fill_reg);
    assign par_idx = PW'((pos_reg - PW'(1)) >> 1);

    assign l_big    = lft_reg.dval > cur_reg.dval;
    assign sd_best  = l_big ? lft_reg : cur_reg;
    assign r_big    = rok_reg && (ent_rdata.dval > sd_best.dval);
    assign sd_move  = l_big || r_big;
    assign sd_child = r_big ? ent_rdata : lft_reg;
    assign sd_top   = r_big ? PW'(r_idx) : PW'(l_idx);

    assign scan_hit  = scan_vld_reg && (ent_rdata.id == peer_id);
    assign scan_more = scan_idx_reg < fill_reg;

    knnh_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rword)
    );

    knnh_ram #(.WIDTH(NRW), .DEPTH(NODES)) u_node_ram (
        .clk   (clk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .re    (nd_re),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == NW'(NODES - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid) state_next = in_ok ? ST_NODE_RD : ST_DONE;
            ST_NODE_RD:
                state_next = ST_NODE_CHK;
            ST_NODE_CHK:
                if (op_reg == OP_SEED)
                    state_next = (nd_rdata[NRW-1 -: FW] < K_FILL) ? ST_SCAN : ST_DONE;
                else
                    state_next = (nd_rdata[NRW-1 -: FW] < K_FILL) ? ST_NEXT : ST_ROOT_RD;
            ST_ROOT_RD:
                state_next = ST_ROOT_CHK;
            ST_ROOT_CHK:
                state_next = (dist_reg >= ent_rdata.dval) ? ST_NEXT : ST_SCAN;
            ST_SCAN:
                if (scan_hit)
                    state_next = (op_reg == OP_SEED) ? ST_DONE : ST_NEXT;
                else if (!scan_more)
                    state_next = (op_reg == OP_SEED) ? ST_SU_RD : ST_NODE_WR;
            ST_SU_RD:
                state_next = (pos_reg == '0) ? ST_NODE_WR : ST_SU_CMP;
            ST_SU_CMP:
                state_next = (cur_reg.dval > ent_rdata.dval) ? ST_SU_RD : ST_NODE_WR;
            ST_NODE_WR:
                state_next = (op_reg == OP_SEED) ? ST_REV_RD_ID : ST_REV_RD_OLD;
            ST_REV_RD_OLD:
                state_next = ST_REV_WR_OLD;
            ST_REV_WR_OLD:
                state_next = ST_REV_RD_ID;
            ST_REV_RD_ID:
                state_next = ST_REV_WR_ID;
            ST_REV_WR_ID:
                state_next = (op_reg == OP_SEED) ? ST_DONE : ST_SD_RL;
            ST_SD_RL:
                state_next = l_in ? ST_SD_RR : ST_NEXT;
            ST_SD_RR:
                state_next = ST_SD_CMP;
            ST_SD_CMP:
                state_next = sd_move ? ST_SD_RL : ST_NEXT;
            ST_NEXT:
                state_next = dir_reg ? ST_DONE : ST_NODE_RD;
            ST_DONE:
                if (out_free) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_widx  = pos_reg;
        ent_ridx  = '0;
        ent_wdata = cur_reg;
        nd_we     = 1'b0;
        nd_re     = 1'b0;
        nd_waddr  = node_idx;
        nd_raddr  = node_idx;
        rv_wdata  = rv_rdata;
        nd_wdata  = {fill_reg, fnew_reg, fold_reg, nd_rdata[RW-1:0]};
        unique case (state_reg)
            ST_CLEAR:
            begin
                nd_we    = 1'b1;
                nd_waddr = clr_reg;
                nd_wdata = '0;
            end
            ST_NODE_RD:
                nd_re = 1'b1;
            ST_ROOT_RD:
                ent_re = 1'b1;
            ST_SCAN:
            begin
                ent_re   = scan_more;
                ent_ridx = PW'(scan_idx_reg);
            end
            ST_SU_RD:
            begin
                ent_we   = (pos_reg == '0);
                ent_re   = (pos_reg != '0);
                ent_ridx = par_idx;
            end
            ST_SU_CMP:
            begin
                ent_we    = 1'b1;
                ent_wdata = (cur_reg.dval > ent_rdata.dval) ? ent_rdata : cur_reg;
            end
            ST_REV_RD_OLD:
            begin
                nd_re    = 1'b1;
                nd_raddr = NW'(root_reg.id);
            end
            ST_REV_WR_OLD:
            begin
                nd_we    = 1'b1;
                nd_waddr = NW'(root_reg.id);
                if (root_reg.is_new)
                    rv_wdata.rnew = (rv_rdata.rnew == '0) ? '0 : rv_rdata.rnew - RCNT_W'(1);
                else
                    rv_wdata.rold = (rv_rdata.rold == '0) ? '0 : rv_rdata.rold - RCNT_W'(1);
                nd_wdata = {nd_rdata[NRW-1 -: NDW], rv_wdata};
            end
            ST_REV_RD_ID:
            begin
                nd_re    = 1'b1;
                nd_raddr = NW'(peer_id);
            end
            ST_REV_WR_ID:
            begin
                nd_we    = 1'b1;
                nd_waddr = NW'(peer_id);
                rv_wdata.rnew = (rv_rdata.rnew == REV_LIMIT) ? REV_LIMIT
                              : rv_rdata.rnew + RCNT_W'(1);
                nd_wdata = {nd_rdata[NRW-1 -: NDW], rv_wdata};
            end
            ST_NODE_WR:
            begin
                nd_we = 1'b1;
                if (op_reg == OP_SEED)
                    nd_wdata = {fill_reg + FW'(1),
                                (fnew_reg == FWD_LIMIT) ? FWD_LIMIT : fnew_reg + FCNT_W'(1),
                                fold_reg, nd_rdata[RW-1:0]};
                else if (!root_reg.is_new)
                    nd_wdata = {fill_reg,
                                (fnew_reg == FWD_LIMIT) ? FWD_LIMIT : fnew_reg + FCNT_W'(1),
                                (fold_reg == '0) ? FCNT_W'(0) : fold_reg - FCNT_W'(1),
                                nd_rdata[RW-1:0]};
            end
            ST_SD_RL:
            begin
                ent_we   = !l_in;
                ent_re   = l_in;
                ent_ridx = PW'(l_idx);
            end
            ST_SD_RR:
            begin
                ent_re   = r_in;
                ent_ridx = PW'(r_idx);
            end
            ST_SD_CMP:
            begin
                ent_we    = 1'b1;
                ent_wdata = sd_move ? sd_child : cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            dir_reg       <= 1'b0;
            acc_reg       <= '0;
            nf_reg        <= 1'b0;
            scan_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                    clr_reg <= clr_reg + NW'(1);
                ST_IDLE:
                    if (in_valid)
                    begin
                        dir_reg <= 1'b0;
                        acc_reg <= '0;
                        nf_reg  <= 1'b0;
                    end
                ST_NODE_CHK:
                begin
                    scan_vld_reg <= 1'b0;
                    if (op_reg != OP_SEED && nd_rdata[NRW-1 -: FW] < K_FILL)
                        nf_reg <= 1'b1;
                end
                ST_ROOT_CHK:
                    scan_vld_reg <= 1'b0;
                ST_SCAN:
                    scan_vld_reg <= scan_more;
                ST_SD_RL:
                    if (!l_in) acc_reg <= acc_reg + 2'd1;
                ST_SD_CMP:
                    if (!sd_move) acc_reg <= acc_reg + 2'd1;
                ST_NODE_WR:
                    if (op_reg == OP_SEED) acc_reg <= 2'd1;
                ST_NEXT:
                    dir_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    op_reg   <= operation;
                    a_reg    <= first_node;
                    b_reg    <= second_node;
                    dist_reg <= distance;
                end
            ST_NODE_CHK:
            begin
                {fill_reg, fnew_reg, fold_reg} <= nd_rdata[NRW-1 -: NDW];
                scan_idx_reg <= '0;
            end
            ST_ROOT_CHK:
            begin
                root_reg     <= ent_rdata;
                scan_idx_reg <= '0;
            end
            ST_SCAN:
            begin
                if (scan_more) scan_idx_reg <= scan_idx_reg + FW'(1);
                if (op_reg == OP_SEED)
                begin
                    cur_reg <= '{dval: SEED_DISTANCE, id: peer_id, is_new: 1'b1};
                    pos_reg <= PW'(fill_reg);
                end
                else
                begin
                    cur_reg <= '{dval: dist_reg, id: peer_id, is_new: 1'b1};
                    pos_reg <= '0;
                end
            end
            ST_SU_CMP:
                if (cur_reg.dval > ent_rdata.dval) pos_reg <= par_idx;
            ST_SD_RR:
            begin
                lft_reg <= ent_rdata;
                rok_reg <= r_in;
            end
            ST_SD_CMP:
                if (sd_move) pos_reg <= sd_top;
            ST_DONE:
                if (out_free)
                begin
                    acc_out_reg <= acc_reg;
                    nf_out_reg  <= nf_reg;
                end
            default:
            begin
            end
        endcase
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign accepted_count = acc_out_reg;
    assign heap_not_full  = nf_out_reg;

    a_no_three: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> accepted_count != 2'd3)
        else $error("accepted_count out of range");

    a_nf_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && heap_not_full |-> accepted_count != 2'd2)
        else $error("non-full heap counted as changed");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> in_stall)
        else $error("request taken during clearing pass");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_idx_reg <= fill_reg)
        else $error("scan ran past heap fill");

endmodule
`default_nettype wire
